>>> design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Types, constants and the control store of the trial-division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int STEP_W          = 3;
	localparam int ROM_DEPTH       = 2 ** STEP_W;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQUARE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_INC,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_NO_IN,
		JC_SMALL,
		JC_SQ_GT,
		JC_DIV_MORE,
		JC_REM_NZ,
		JC_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  hold;     // taken jump suppresses op (wait step)
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic below_two;
		logic sq_gt;
		logic div_more;
		logic rem_nz;
	} dp_stat_t;

	localparam step_t STEP_IDLE = step_t'(0);
	localparam step_t STEP_CHK  = step_t'(1);
	localparam step_t STEP_SQ   = step_t'(2);
	localparam step_t STEP_CMP  = step_t'(3);
	localparam step_t STEP_DIV  = step_t'(4);
	localparam step_t STEP_TEST = step_t'(5);
	localparam step_t STEP_EMIT = step_t'(6);
	localparam step_t STEP_RET  = step_t'(7);

	function automatic ctrl_word_t ucode(input step_t s);
		ctrl_word_t w;
		w = '{op: OP_NOP, cond: JC_ALWAYS, hold: 1'b0, target: STEP_IDLE};
		unique case (s)
			STEP_IDLE: w = '{op: OP_LOAD,     cond: JC_NO_IN,    hold: 1'b1,
					target: STEP_IDLE};
			STEP_CHK:  w = '{op: OP_NOP,      cond: JC_SMALL,    hold: 1'b0,
					target: STEP_EMIT};
			STEP_SQ:   w = '{op: OP_SQUARE,   cond: JC_NEVER,    hold: 1'b0,
					target: STEP_IDLE};
			STEP_CMP:  w = '{op: OP_DIV_INIT, cond: JC_SQ_GT,    hold: 1'b0,
					target: STEP_EMIT};
			STEP_DIV:  w = '{op: OP_DIV_STEP, cond: JC_DIV_MORE, hold: 1'b0,
					target: STEP_DIV};
			STEP_TEST: w = '{op: OP_INC,      cond: JC_REM_NZ,   hold: 1'b0,
					target: STEP_SQ};
			STEP_EMIT: w = '{op: OP_EMIT,     cond: JC_OUT_BUSY, hold: 1'b1,
					target: STEP_EMIT};
			STEP_RET:  w = '{op: OP_NOP,      cond: JC_ALWAYS,   hold: 1'b0,
					target: STEP_IDLE};
			default:   w = '{op: OP_NOP,      cond: JC_ALWAYS,   hold: 1'b0,
					target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> design/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath
// Candidate, trial divisor, square and bit-serial restoring divider.
// ----------------------------------------------------------------------------
module tdpt_datapath import tdpt_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_ctrl_t               ctrl,
	input  logic [VALUE_WIDTH-1:0] cand,
	output dp_stat_t               stat,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   prime
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]   n_q;
	logic [W-1:0]   d_q;
	logic [2*W-1:0] sq_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   quo_q;
	logic [CW-1:0]  cnt_q;
	logic           prime_q;

	logic [W:0]     shifted;
	logic [W:0]     diff;
	logic           sq_gt;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, d_q};
	assign sq_gt   = sq_q > {{W{1'b0}}, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			d_q     <= '0;
			sq_q    <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			prime_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				OP_LOAD: begin
					n_q     <= cand;
					d_q     <= W'(2);
					prime_q <= 1'b0;
				end
				OP_SQUARE: sq_q <= {{W{1'b0}}, d_q} * {{W{1'b0}}, d_q};
				OP_DIV_INIT: begin
					prime_q <= sq_gt;
					rem_q   <= '0;
					quo_q   <= n_q;
					cnt_q   <= CW'(W);
				end
				OP_DIV_STEP: begin
					quo_q <= {quo_q[W-2:0], 1'b0};
					cnt_q <= cnt_q - CW'(1);
					if (!diff[W]) begin
						rem_q <= diff[W-1:0];
					end else begin
						rem_q <= shifted[W-1:0];
					end
				end
				OP_INC: d_q <= d_q + W'(1);
				default: ;
			endcase
		end
	end

	assign stat.below_two = (n_q[W-1:1] == '0);
	assign stat.sq_gt     = sq_gt;
	assign stat.div_more  = (cnt_q != CW'(1));
	assign stat.rem_nz    = (rem_q != '0);
	assign value          = n_q;
	assign prime          = prime_q;

endmodule

>>> design/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Trial-division primality test run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// channel  dir  tdata                 tuser
// s_axis   in   candidate             -
// m_axis   out  tested_value          prime_flag
//
// Per item: candidates 0 and 1 go straight to the result; else each divisor
// tried is squared, its square compared with the candidate, and the divide
// loop (one quotient bit per cycle) run on it, until the square test ends
// the search or a factor ends it.
// The output register lets the next candidate enter while a result is
// stalled; reset clears sequencer and datapath, not the result data, no sweep.
// ----------------------------------------------------------------------------
module trial_division_prime_test import tdpt_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [8*((VALUE_WIDTH+7)/8)-1:0]       s_axis_tdata,  // candidate
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [8*((VALUE_WIDTH+7)/8)-1:0]       m_axis_tdata,  // tested_value
	output logic                                   m_axis_tuser   // prime_flag
);

	localparam int W  = VALUE_WIDTH;
	localparam int TW = 8 * ((W + 7) / 8);

	step_t          upc_q;
	ctrl_word_t     cw;
	logic           taken;
	logic           exec;
	dp_ctrl_t       dp_ctrl;
	dp_stat_t       dp_stat;
	logic [W-1:0]   dp_value;
	logic           dp_prime;
	logic           out_busy;
	logic [W-1:0]   out_val_q;
	logic           out_flag_q;
	logic           out_vld_q;

	assign cw       = ucode(upc_q);
	assign out_busy = out_vld_q && !m_axis_tready;

	always_comb begin
		unique case (cw.cond)
			JC_NEVER:    taken = 1'b0;
			JC_ALWAYS:   taken = 1'b1;
			JC_NO_IN:    taken = !s_axis_tvalid;
			JC_SMALL:    taken = dp_stat.below_two;
			JC_SQ_GT:    taken = dp_stat.sq_gt;
			JC_DIV_MORE: taken = dp_stat.div_more;
			JC_REM_NZ:   taken = dp_stat.rem_nz;
			JC_OUT_BUSY: taken = out_busy;
			default:     taken = 1'b1;
		endcase
	end

	assign exec       = !(cw.hold && taken);
	assign dp_ctrl.op = exec ? cw.op : OP_NOP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= taken ? cw.target : upc_q + step_t'(1);
		end
	end

	tdpt_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (dp_ctrl),
		.cand  (s_axis_tdata[W-1:0]),
		.stat  (dp_stat),
		.value (dp_value),
		.prime (dp_prime)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (dp_ctrl.op == OP_EMIT) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.op == OP_EMIT) begin
			out_val_q  <= dp_value;
			out_flag_q <= dp_prime;
		end
	end

	assign s_axis_tready = (upc_q == STEP_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = TW'(out_val_q);
	assign m_axis_tuser  = out_flag_q;

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (upc_q == STEP_CHK))
		else $error("transfer did not start the test");

	a_prime_ge_two: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[W-1:1] != '0))
		else $error("value below two flagged prime");

	a_even_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser && !m_axis_tdata[0]) |->
		(m_axis_tdata[W-1:0] == W'(2)))
		else $error("even value other than two flagged prime");

	a_emit_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_ctrl.op == OP_EMIT) |-> !out_busy)
		else $error("result overwritten while stalled");

endmodule
